/* rtl/lbm_pkg.sv */
// Package for the lux to brightness mapper: widths, codes, pipeline tag
// types and the constant log2 mantissa table. No dependencies.
`default_nettype none

package lbm_pkg;

  localparam int LUX_W      = 20;
  localparam int LOG_DEPTH  = 64;
  localparam int IDX_W      = $clog2(LOG_DEPTH);
  localparam int FRAC_W     = 32 - IDX_W;
  localparam int BRIGHT_W   = 7;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = LUX_W;
  localparam int V_W        = LUX_W + 1;
  localparam int POS_W      = $clog2(V_W);
  localparam int LOG_W      = $clog2(V_W * 65536 + 1);
  localparam int NUM_W      = LOG_W + BRIGHT_W;
  localparam int QUO_W      = BRIGHT_W;
  localparam int ENTRY_W    = 17;
  localparam int ONE_LUX    = 16;
  localparam int BRIGHT_MAX = 100;

  localparam logic [LUX_W-1:0]    LUX_CEIL_RESET    = LUX_W'(16000);
  localparam logic [BRIGHT_W-1:0] BRIGHT_FLOOR_RESET = BRIGHT_W'(10);
  localparam logic [BRIGHT_W-1:0] BRIGHT_CEIL_RESET  = BRIGHT_W'(100);

  typedef enum logic [MODE_W-1:0] {
    MODE_LINEAR    = 2'd0,
    MODE_LOG       = 2'd1,
    MODE_THRESHOLD = 2'd2,
    MODE_LINEAR_ALT = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE         = 3'd0,
    REG_LUX_FLOOR    = 3'd1,
    REG_LUX_CEILING  = 3'd2,
    REG_BRIGHT_FLOOR = 3'd3,
    REG_BRIGHT_CEIL  = 3'd4
  } cfg_reg_t;

  typedef logic [ENTRY_W-1:0] lut_t [0:LOG_DEPTH];

  // Side data for the linear and threshold paths, carried next to the log unit.
  typedef struct packed {
    logic [LUX_W-1:0] lin_num;
    logic             lin_ok;
    logic             thr_hit;
  } side_t;

  // Travels with an item through the divider.
  typedef struct packed {
    logic                use_div;
    logic                neg;
    logic [BRIGHT_W-1:0] fixed_b;
  } div_tag_t;

  // log2(1 + i/N) in Q16 by repeated squaring of a Q30 value.
  function automatic lut_t build_log_table();
    lut_t        t;
    logic [63:0] y;
    logic [15:0] acc;
    for (int i = 0; i <= LOG_DEPTH; i++) begin
      if (i >= LOG_DEPTH) begin
        t[i] = ENTRY_W'(65536);
      end else begin
        y   = (64'd1 << 30) + ((64'(i) << 30) / LOG_DEPTH);
        acc = '0;
        for (int b = 15; b >= 0; b--) begin
          y = (y * y) >> 30;
          if (y >= (64'd1 << 31)) begin
            acc[b] = 1'b1;
            y      = y >> 1;
          end
        end
        t[i] = ENTRY_W'(acc);
      end
    end
    return t;
  endfunction

  localparam lut_t LOG_TABLE = build_log_table();

endpackage

`default_nettype wire

/* rtl/lbm_if.sv */
// Channel interfaces of the lux to brightness mapper: reading input,
// brightness output and register write port. Depends on lbm_pkg.
`default_nettype none

interface lbm_in_if import lbm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LUX_W-1:0] lux_reading;
  modport source(output valid, output lux_reading, input ready);
  modport sink(input valid, input lux_reading, output ready);
endinterface

interface lbm_out_if import lbm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BRIGHT_W-1:0] brightness_pct;
  modport source(output valid, output brightness_pct, input ready);
  modport sink(input valid, input brightness_pct, output ready);
endinterface

interface lbm_cfg_if import lbm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/lux_to_brightness_mapper.sv */
// Top level of the lux to brightness mapper: registers, window clamp, three
// log units, scaling multiply, divider and output stage. Depends on lbm_pkg,
// lbm_if, lbm_log2 and lbm_divider.
//
//   Channel     Dir  Payload                 Handshake
//   lux_in      in   lux_reading[19:0]       valid/ready
//   bright_out  out  brightness_pct[6:0]     valid/ready
//   cfg         in   index[2:0], data[19:0]  valid/ready, always ready
//
// One transaction enters per cycle unless the output stalls; each result passes
// through the clamp, three log, scaling, seven divider and output stages.
// All stages share one enable, so a stall at the output holds every stage.
// Reset clears the stage valid bits and loads the register reset values.
`default_nettype none

module lux_to_brightness_mapper import lbm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  lbm_in_if.sink     lux_in,
  lbm_out_if.source  bright_out,
  lbm_cfg_if.sink    cfg
);

  localparam int NST = 6 + QUO_W;

  logic [MODE_W-1:0]   mode;
  logic [LUX_W-1:0]    lux_floor;
  logic [LUX_W-1:0]    lux_ceiling;
  logic [BRIGHT_W-1:0] bright_floor;
  logic [BRIGHT_W-1:0] bright_ceiling;

  logic [NST-1:0] vld;
  logic           en;

  assign en           = !vld[NST-1] || bright_out.ready;
  assign lux_in.ready = en;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_LINEAR;
      lux_floor      <= '0;
      lux_ceiling    <= LUX_CEIL_RESET;
      bright_floor   <= BRIGHT_FLOOR_RESET;
      bright_ceiling <= BRIGHT_CEIL_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MODE:         mode           <= cfg.data[MODE_W-1:0];
        REG_LUX_FLOOR:    lux_floor      <= cfg.data[LUX_W-1:0];
        REG_LUX_CEILING:  lux_ceiling    <= cfg.data[LUX_W-1:0];
        REG_BRIGHT_FLOOR: bright_floor   <= cfg.data[BRIGHT_W-1:0];
        REG_BRIGHT_CEIL:  bright_ceiling <= cfg.data[BRIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], lux_in.valid};
    end
  end

  // Stage 0: clamp into the window (floor first, then ceiling).
  logic [LUX_W-1:0] lux_lo;
  logic [LUX_W-1:0] lux_c;
  logic [LUX_W-1:0] s0_lux;

  always_comb begin
    lux_lo = (lux_in.lux_reading < lux_floor) ? lux_floor : lux_in.lux_reading;
    lux_c  = (lux_lo > lux_ceiling) ? lux_ceiling : lux_lo;
  end

  always_ff @(posedge clk) begin
    if (en) s0_lux <= lux_c;
  end

  // Stages 1 to 3: log units, with the linear and threshold data alongside.
  logic [LOG_W-1:0] l_cur;
  logic [LOG_W-1:0] l_min;
  logic [LOG_W-1:0] l_max;

  lbm_log2 u_log_cur (
    .clk (clk), .en (en),
    .x   (V_W'(s0_lux) + V_W'(ONE_LUX)),
    .y   (l_cur)
  );

  lbm_log2 u_log_min (
    .clk (clk), .en (en),
    .x   (V_W'(lux_floor) + V_W'(ONE_LUX)),
    .y   (l_min)
  );

  lbm_log2 u_log_max (
    .clk (clk), .en (en),
    .x   (V_W'(lux_ceiling) + V_W'(ONE_LUX)),
    .y   (l_max)
  );

  side_t side [1:3];

  always_ff @(posedge clk) begin
    if (en) begin
      side[1].lin_num <= s0_lux - lux_floor;
      side[1].lin_ok  <= lux_ceiling > lux_floor;
      side[1].thr_hit <= {s0_lux, 1'b0} >= (V_W'(lux_floor) + V_W'(lux_ceiling));
      side[2]         <= side[1];
      side[3]         <= side[2];
    end
  end

  // Stage 4: choose numerator and denominator, scale by the brightness span.
  logic signed [LOG_W:0]    range_s;
  logic signed [LOG_W:0]    part_s;
  logic signed [BRIGHT_W:0] span;
  logic [BRIGHT_W-1:0]      span_abs;
  logic [LOG_W-1:0]         base;
  logic [LOG_W-1:0]         den_c;
  div_tag_t                 tag_c;

  logic [NUM_W-1:0] num_d;
  logic [LOG_W-1:0] den_d;
  div_tag_t         tag_d;

  always_comb begin
    range_s  = $signed({1'b0, l_max}) - $signed({1'b0, l_min});
    part_s   = $signed({1'b0, l_cur}) - $signed({1'b0, l_min});
    span     = $signed({1'b0, bright_ceiling}) - $signed({1'b0, bright_floor});
    span_abs = span[BRIGHT_W] ? BRIGHT_W'(-span) : span[BRIGHT_W-1:0];
    tag_c.neg     = span[BRIGHT_W];
    tag_c.fixed_b = bright_floor;
    tag_c.use_div = 1'b0;
    base          = '0;
    den_c         = LOG_W'(1);
    case (mode)
      MODE_LOG: begin
        tag_c.use_div = range_s > 0;
        base          = part_s[LOG_W] ? '0 : part_s[LOG_W-1:0];
        den_c         = range_s[LOG_W-1:0];
      end
      MODE_THRESHOLD: begin
        tag_c.fixed_b = side[3].thr_hit ? bright_ceiling : bright_floor;
      end
      default: begin
        tag_c.use_div = side[3].lin_ok;
        base          = LOG_W'(side[3].lin_num);
        den_c         = LOG_W'(lux_ceiling - lux_floor);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_d <= NUM_W'(base) * NUM_W'(span_abs);
      den_d <= den_c;
      tag_d <= tag_c;
    end
  end

  // Stages 5 to 11: quotient bits.
  logic [QUO_W-1:0] quo;
  div_tag_t         tag_q;

  lbm_divider u_div (
    .clk     (clk),
    .en      (en),
    .num     (num_d),
    .den     (den_d),
    .tag_in  (tag_d),
    .quo     (quo),
    .tag_out (tag_q)
  );

  // Output stage: apply the sign and add the floor, or take the fixed value; saturate to 0..100.
  logic signed [BRIGHT_W+1:0] sum;
  logic [BRIGHT_W-1:0]        pct;

  always_comb begin
    if (!tag_q.use_div) begin
      sum = $signed({2'b00, tag_q.fixed_b});
    end else if (tag_q.neg) begin
      sum = $signed({2'b00, bright_floor}) - $signed({2'b00, quo});
    end else begin
      sum = $signed({2'b00, bright_floor}) + $signed({2'b00, quo});
    end
    if (sum < 0) begin
      pct = '0;
    end else if (sum > (BRIGHT_W+2)'(BRIGHT_MAX)) begin
      pct = BRIGHT_W'(BRIGHT_MAX);
    end else begin
      pct = sum[BRIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) bright_out.brightness_pct <= pct;
  end

  assign bright_out.valid = vld[NST-1];

endmodule

`default_nettype wire

/* rtl/lbm_log2.sv */
// Three-stage pipelined log2 unit in unsigned Q5.16: leading-one search,
// table lookup with interpolation product, final sum. Depends on lbm_pkg.
`default_nettype none

module lbm_log2 import lbm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [V_W-1:0]   x,
  output logic      [LOG_W-1:0] y
);

  logic [POS_W-1:0]  pos;
  logic [31:0]       mant;
  logic [V_W+31:0]   wide;
  logic [5:0]        sh;

  logic [POS_W-1:0]  p1;
  logic [IDX_W-1:0]  idx1;
  logic [FRAC_W-1:0] frac1;

  logic [ENTRY_W-1:0]        lo;
  logic [ENTRY_W-1:0]        hi;
  logic [ENTRY_W-1:0]        diff;
  logic [ENTRY_W+FRAC_W-1:0] prod;
  logic [IDX_W:0]            idx_hi;

  logic [POS_W-1:0]   p2;
  logic [ENTRY_W-1:0] lo2;
  logic [ENTRY_W-1:0] interp2;

  always_comb begin
    pos = '0;
    for (int i = 0; i < V_W; i++) begin
      if (x[i]) pos = POS_W'(i);
    end
    sh   = 6'd32 - 6'(pos);
    wide = (V_W+32)'(x) << sh;
    mant = wide[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1    <= pos;
      idx1  <= mant[31:FRAC_W];
      frac1 <= mant[FRAC_W-1:0];
    end
  end

  always_comb begin
    idx_hi = {1'b0, idx1} + (IDX_W+1)'(1);
    lo     = LOG_TABLE[{1'b0, idx1}];
    hi     = LOG_TABLE[idx_hi];
    diff   = hi - lo;
    prod   = (ENTRY_W+FRAC_W)'(diff) * (ENTRY_W+FRAC_W)'(frac1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2      <= p1;
      lo2     <= lo;
      interp2 <= prod[ENTRY_W+FRAC_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= (LOG_W'(p2) << 16) + LOG_W'(lo2) + LOG_W'(interp2);
    end
  end

endmodule

`default_nettype wire

/* rtl/lbm_divider.sv */
// Pipelined restoring divider, one quotient bit per stage, with a tag that
// moves alongside. The quotient is known to fit QUO_W bits. Depends on lbm_pkg.
`default_nettype none

module lbm_divider import lbm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [LOG_W-1:0] den,
  input  wire div_tag_t         tag_in,
  output logic      [QUO_W-1:0] quo,
  output div_tag_t              tag_out
);

  logic [NUM_W-1:0] rem   [0:QUO_W];
  logic [LOG_W-1:0] dens  [0:QUO_W];
  logic [QUO_W-1:0] qs    [0:QUO_W];
  div_tag_t         tags  [0:QUO_W];

  assign rem[0]  = num;
  assign dens[0] = den;
  assign qs[0]   = '0;
  assign tags[0] = tag_in;

  for (genvar j = 0; j < QUO_W; j++) begin : g_step
    localparam int K = QUO_W - 1 - j;
    logic [NUM_W-1:0] trial;
    logic             fits;

    always_comb begin
      trial = NUM_W'(dens[j]) << K;
      fits  = rem[j] >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1]  <= fits ? rem[j] - trial : rem[j];
        dens[j+1] <= dens[j];
        qs[j+1]   <= qs[j] | (fits ? (QUO_W'(1) << K) : '0);
        tags[j+1] <= tags[j];
      end
    end
  end

  assign quo     = qs[QUO_W];
  assign tag_out = tags[QUO_W];

endmodule

`default_nettype wire

/* rtl/lbm_checker.sv */
// Port-level checker for the lux to brightness mapper and its bind.
// Depends on lbm_pkg and the top level lux_to_brightness_mapper.
`default_nettype none

module lbm_checker import lbm_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [BRIGHT_W-1:0] out_pct,
  input wire logic                cfg_ready
);

  // A pending result is not dropped while the sink stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped during stall");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_pct <= BRIGHT_W'(BRIGHT_MAX))
    else $error("brightness above saturation limit");

  // With no result waiting, the input side never stalls.
  a_in_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("register port not ready");

endmodule

bind lux_to_brightness_mapper lbm_checker u_lbm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (lux_in.ready),
  .out_valid (bright_out.valid),
  .out_ready (bright_out.ready),
  .out_pct   (bright_out.brightness_pct),
  .cfg_ready (cfg.ready)
);

`default_nettype wire
